// ===== design/tcd_pkg.sv =====
// ----------------------------------------------------------------------------
// tcd_pkg
// Types, codes and helpers shared by the two-class task dispatcher.
// ----------------------------------------------------------------------------
package tcd_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W       = CNT_W + 7;

	localparam logic [1:0] REQ_TASK   = 2'd0;
	localparam logic [1:0] REQ_DONE_A = 2'd1;
	localparam logic [1:0] REQ_DONE_B = 2'd2;

	localparam logic [2:0] OP_OPEN    = 3'd0;
	localparam logic [2:0] OP_BATTERY = 3'd4;

	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_NORMAL = 2'd1;
	localparam logic [1:0] MODE_URGENT = 2'd2;

	localparam logic RES_DISPATCH = 1'b0;
	localparam logic RES_BUSY     = 1'b1;

	localparam logic [3:0] ACTIVE_MAX        = 4'd15;
	localparam logic [5:0] MAX_WAITING_RESET = 6'd21;

	localparam logic [2:0] REG_MAX_WAITING = 3'd0;

	typedef enum logic {
		S_ACCEPT,
		S_READ
	} state_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  box;
		logic [15:0] tag;
	} task_t;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	function automatic logic [3:0] active_inc(input logic [3:0] a);
		return (a < ACTIVE_MAX) ? a + 4'd1 : a;
	endfunction

	function automatic logic [3:0] active_dec(input logic [3:0] a);
		return (a != 4'd0) ? a - 4'd1 : a;
	endfunction

	function automatic ptr_t ptr_next(input ptr_t p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic queue_full(input cnt_t cnt, input logic [5:0] max_waiting);
		logic [CMP_W-1:0] c_x;
		logic [CMP_W-1:0] m_x;
		logic [CMP_W-1:0] d_x;
		c_x = CMP_W'(cnt);
		m_x = CMP_W'(max_waiting);
		d_x = CMP_W'(QUEUE_DEPTH);
		return c_x >= ((m_x < d_x) ? m_x : d_x);
	endfunction

	function automatic logic [5:0] waiting_field(input cnt_t cnt);
		logic [CNT_W+5:0] c_x;
		c_x = {6'd0, cnt};
		return c_x[5:0];
	endfunction

endpackage

// ===== design/tcd_task_if.sv =====
// ----------------------------------------------------------------------------
// tcd_task_if
// Input channel: one task request or completion event per beat.
// ----------------------------------------------------------------------------
interface tcd_task_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [2:0]  task_op;
	logic [7:0]  box_id;
	logic [15:0] task_tag;

	modport source (output valid, req_type, task_op, box_id, task_tag, input ready);
	modport sink (input valid, req_type, task_op, box_id, task_tag, output ready);
endinterface

// ===== design/tcd_result_if.sv =====
// ----------------------------------------------------------------------------
// tcd_result_if
// Output channel: one dispatch or busy rejection per beat.
// ----------------------------------------------------------------------------
interface tcd_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [2:0]  out_op;
	logic [7:0]  out_box;
	logic [15:0] out_tag;
	logic [1:0]  mode_now;
	logic [3:0]  active_now;
	logic [5:0]  urgent_waiting;
	logic [5:0]  normal_waiting;

	modport source (output valid, result_kind, out_op, out_box, out_tag, mode_now,
		active_now, urgent_waiting, normal_waiting, input ready);
	modport sink (input valid, result_kind, out_op, out_box, out_tag, mode_now,
		active_now, urgent_waiting, normal_waiting, output ready);
endinterface

// ===== design/tcd_ram.sv =====
// ----------------------------------------------------------------------------
// tcd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/two_class_task_dispatcher_core.sv =====
// ----------------------------------------------------------------------------
// two_class_task_dispatcher_core
// Hands urgent and normal tasks to one executor, queues the ones that must
// wait in two RAM-backed FIFOs and rejects them busy once a FIFO is full.
//
//   Channel     Direction  Beat contents
//   task_in     in         req_type, task_op, box_id, task_tag
//   result_out  out        result_kind, task fields, mode and fill after step
//   apb         in/out     max_waiting at byte address 0
//
// An event that pops nothing is done when accepted; one that pops a waiting
// task also passes through S_READ, where no new beat is taken, because the
// task is read from the registered read port of the FIFO RAM. The result
// register frees the input side: a new beat is taken while the result is
// being taken in the same cycle. Reset restores idle mode, zero active
// count and empty FIFOs at once, without a clearing pass.
// ----------------------------------------------------------------------------
module two_class_task_dispatcher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	tcd_task_if.sink    task_in,
	tcd_result_if.source result_out
);

	tcd_pkg::state_t state_q, state_d;

	logic [5:0]     max_waiting_q;
	logic [1:0]     mode_q;
	logic [3:0]     active_q;
	tcd_pkg::ptr_t  u_head_q, u_tail_q, n_head_q, n_tail_q;
	tcd_pkg::cnt_t  u_cnt_q, n_cnt_q;

	logic           out_valid_q;
	logic           out_kind_q;
	tcd_pkg::task_t out_task_q;
	logic [1:0]     out_mode_q;
	logic [3:0]     out_active_q;
	logic [5:0]     out_u_wait_q;
	logic [5:0]     out_n_wait_q;
	logic           rd_urgent_q;

	tcd_pkg::task_t in_task;
	tcd_pkg::task_t u_rdata, n_rdata;
	logic           accept;
	logic           in_ready;

	logic       have, kind, pop_u, pop_n, push_u, push_n, check_normal;
	logic [1:0] mode_d;
	logic [3:0] active_d;
	logic       u_full, n_full;
	tcd_pkg::cnt_t u_cnt_d, n_cnt_d;

	assign in_task.op  = task_in.task_op;
	assign in_task.box = task_in.box_id;
	assign in_task.tag = task_in.task_tag;

	assign pready = 1'b1;
	assign prdata = (paddr == tcd_pkg::REG_MAX_WAITING) ? {26'd0, max_waiting_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_waiting_q <= tcd_pkg::MAX_WAITING_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			max_waiting_q <= pwdata[5:0];
		end
	end

	assign u_full = tcd_pkg::queue_full(u_cnt_q, max_waiting_q);
	assign n_full = tcd_pkg::queue_full(n_cnt_q, max_waiting_q);

	always_comb begin
		mode_d       = mode_q;
		active_d     = active_q;
		have         = 1'b0;
		kind         = tcd_pkg::RES_DISPATCH;
		pop_u        = 1'b0;
		pop_n        = 1'b0;
		push_u       = 1'b0;
		push_n       = 1'b0;
		check_normal = 1'b0;
		if (task_in.req_type == tcd_pkg::REQ_TASK && task_in.task_op == tcd_pkg::OP_OPEN) begin
			if (mode_q == tcd_pkg::MODE_URGENT) begin
				if (u_full) begin
					have = 1'b1;
					kind = tcd_pkg::RES_BUSY;
				end else begin
					push_u = 1'b1;
				end
			end else begin
				have     = 1'b1;
				mode_d   = tcd_pkg::MODE_URGENT;
				active_d = tcd_pkg::active_inc(active_q);
			end
		end else if (task_in.req_type == tcd_pkg::REQ_TASK
			&& task_in.task_op <= tcd_pkg::OP_BATTERY) begin
			if (mode_q != tcd_pkg::MODE_IDLE) begin
				if (n_full) begin
					have = 1'b1;
					kind = tcd_pkg::RES_BUSY;
				end else begin
					push_n = 1'b1;
				end
			end else begin
				have     = 1'b1;
				mode_d   = tcd_pkg::MODE_NORMAL;
				active_d = tcd_pkg::active_inc(active_q);
			end
		end else if (task_in.req_type == tcd_pkg::REQ_DONE_A
			|| task_in.req_type == tcd_pkg::REQ_DONE_B) begin
			active_d = tcd_pkg::active_dec(active_q);
			if (task_in.req_type == tcd_pkg::REQ_DONE_A) begin
				if (u_cnt_q != '0) begin
					have     = 1'b1;
					pop_u    = 1'b1;
					mode_d   = tcd_pkg::MODE_URGENT;
					active_d = tcd_pkg::active_inc(active_d);
				end else begin
					mode_d       = tcd_pkg::MODE_NORMAL;
					check_normal = (active_d == 4'd0);
				end
			end else begin
				check_normal = (mode_q != tcd_pkg::MODE_URGENT) && (active_d == 4'd0);
			end
			if (check_normal) begin
				if (n_cnt_q != '0) begin
					have     = 1'b1;
					pop_n    = 1'b1;
					mode_d   = tcd_pkg::MODE_NORMAL;
					active_d = tcd_pkg::active_inc(active_d);
				end else begin
					mode_d = tcd_pkg::MODE_IDLE;
				end
			end
		end
		if (mode_d == tcd_pkg::MODE_IDLE && !have) begin
			if (u_cnt_q != '0) begin
				have     = 1'b1;
				pop_u    = 1'b1;
				mode_d   = tcd_pkg::MODE_URGENT;
				active_d = tcd_pkg::active_inc(active_d);
			end else if (n_cnt_q != '0) begin
				have     = 1'b1;
				pop_n    = 1'b1;
				mode_d   = tcd_pkg::MODE_NORMAL;
				active_d = tcd_pkg::active_inc(active_d);
			end
		end
	end

	assign u_cnt_d = u_cnt_q + tcd_pkg::cnt_t'(push_u) - tcd_pkg::cnt_t'(pop_u);
	assign n_cnt_d = n_cnt_q + tcd_pkg::cnt_t'(push_n) - tcd_pkg::cnt_t'(pop_n);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			tcd_pkg::S_ACCEPT: begin
				in_ready = !out_valid_q || result_out.ready;
				if (task_in.valid && in_ready && (pop_u || pop_n)) begin
					state_d = tcd_pkg::S_READ;
				end
			end
			tcd_pkg::S_READ: begin
				state_d = tcd_pkg::S_ACCEPT;
			end
			default: begin
				state_d = tcd_pkg::S_ACCEPT;
			end
		endcase
	end

	assign task_in.ready = in_ready;
	assign accept        = task_in.valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcd_pkg::S_ACCEPT;
			mode_q      <= tcd_pkg::MODE_IDLE;
			active_q    <= 4'd0;
			u_head_q    <= '0;
			u_tail_q    <= '0;
			u_cnt_q     <= '0;
			n_head_q    <= '0;
			n_tail_q    <= '0;
			n_cnt_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				mode_q   <= mode_d;
				active_q <= active_d;
				u_cnt_q  <= u_cnt_d;
				n_cnt_q  <= n_cnt_d;
				if (push_u) begin
					u_tail_q <= tcd_pkg::ptr_next(u_tail_q);
				end
				if (pop_u) begin
					u_head_q <= tcd_pkg::ptr_next(u_head_q);
				end
				if (push_n) begin
					n_tail_q <= tcd_pkg::ptr_next(n_tail_q);
				end
				if (pop_n) begin
					n_head_q <= tcd_pkg::ptr_next(n_head_q);
				end
			end
			if (state_q == tcd_pkg::S_READ) begin
				out_valid_q <= 1'b1;
			end else if (accept) begin
				out_valid_q <= have && !pop_u && !pop_n;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_kind_q   <= kind;
			out_task_q   <= in_task;
			out_mode_q   <= mode_d;
			out_active_q <= active_d;
			out_u_wait_q <= tcd_pkg::waiting_field(u_cnt_d);
			out_n_wait_q <= tcd_pkg::waiting_field(n_cnt_d);
			rd_urgent_q  <= pop_u;
		end else if (state_q == tcd_pkg::S_READ) begin
			out_task_q <= rd_urgent_q ? u_rdata : n_rdata;
		end
	end

	tcd_ram #(
		.WIDTH($bits(tcd_pkg::task_t)),
		.DEPTH(tcd_pkg::QUEUE_DEPTH)
	) u_urgent_ram (
		.clk  (clk),
		.we   (accept && push_u),
		.waddr(u_tail_q),
		.wdata(in_task),
		.raddr(u_head_q),
		.rdata(u_rdata)
	);

	tcd_ram #(
		.WIDTH($bits(tcd_pkg::task_t)),
		.DEPTH(tcd_pkg::QUEUE_DEPTH)
	) u_normal_ram (
		.clk  (clk),
		.we   (accept && push_n),
		.waddr(n_tail_q),
		.wdata(in_task),
		.raddr(n_head_q),
		.rdata(n_rdata)
	);

	assign result_out.valid          = out_valid_q;
	assign result_out.result_kind    = out_kind_q;
	assign result_out.out_op         = out_task_q.op;
	assign result_out.out_box        = out_task_q.box;
	assign result_out.out_tag        = out_task_q.tag;
	assign result_out.mode_now       = out_mode_q;
	assign result_out.active_now     = out_active_q;
	assign result_out.urgent_waiting = out_u_wait_q;
	assign result_out.normal_waiting = out_n_wait_q;

endmodule

// ===== design/tcd_checker.sv =====
// ----------------------------------------------------------------------------
// tcd_checker
// Port-level checks on the result channel of the task dispatcher.
// ----------------------------------------------------------------------------
module tcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic        result_kind,
	input logic [2:0]  out_op,
	input logic [1:0]  mode_now,
	input logic [3:0]  active_now
);

	// A result beat that is not taken must stay offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result beat withdrawn before it was taken");

	// Every result leaves the executor busy in normal or urgent mode.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (mode_now == tcd_pkg::MODE_NORMAL || mode_now == tcd_pkg::MODE_URGENT))
		else $error("result reported with idle or invalid mode");

	// A dispatched task is counted as active.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && result_kind == tcd_pkg::RES_DISPATCH |-> active_now != 4'd0)
		else $error("dispatch reported with zero active tasks");

	// An urgent task is only rejected while urgent work is running.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && result_kind == tcd_pkg::RES_BUSY && out_op == tcd_pkg::OP_OPEN
		|-> mode_now == tcd_pkg::MODE_URGENT)
		else $error("urgent task rejected outside urgent mode");

endmodule

bind two_class_task_dispatcher_core tcd_checker u_tcd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (result_out.valid),
	.ready      (result_out.ready),
	.result_kind(result_out.result_kind),
	.out_op     (result_out.out_op),
	.mode_now   (result_out.mode_now),
	.active_now (result_out.active_now)
);

// ===== sim/tb_two_class_task_dispatcher_core.sv =====
// ----------------------------------------------------------------------------
// tb_two_class_task_dispatcher_core
// Self-checking bench for the two-class task dispatcher. A clocked driver
// sends request and completion beats from a queue. A transaction-level
// predictor of mode, active count and both waiting queues computes the
// dispatch or busy result for each accepted beat. A clocked monitor checks
// every result beat against the oldest prediction. The run goes through
// several max_waiting settings, among them the extremes, with random gaps
// and stalls on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_two_class_task_dispatcher_core;

	localparam logic [1:0] REQ_OTHER     = 2'd3;
	localparam logic [2:0] OP_CLOSE      = 3'd1;
	localparam logic [2:0] OP_DOOR_STAT  = 3'd2;
	localparam logic [2:0] OP_PAPER_STAT = 3'd3;
	localparam int         HOLD_CYCLES   = 400;

	typedef struct {
		logic [1:0]  req;
		logic [2:0]  op;
		logic [7:0]  box;
		logic [15:0] tag;
	} dispatch_req_t;

	typedef struct packed {
		logic           kind;
		tcd_pkg::task_t job;
		logic [1:0]     mode;
		logic [3:0]     active;
		logic [5:0]     urgent_fill;
		logic [5:0]     normal_fill;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tcd_task_if   task_ch ();
	tcd_result_if result_ch ();

	two_class_task_dispatcher_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.task_in    (task_ch),
		.result_out (result_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [1:0]     pred_mode;
	logic [3:0]     pred_active;
	logic [5:0]     pred_max_waiting;
	tcd_pkg::task_t urgent_wait[$];
	tcd_pkg::task_t normal_wait[$];
	outcome_t       expected_results[$];
	dispatch_req_t  pending_events[$];
	dispatch_req_t  on_wire;
	int             send_gap;
	int             stall_left;
	int             errors = 0;
	logic           quiet = 1'b0;
	logic           pressure_go = 1'b0;
	logic           rx_hold = 1'b0;

	function automatic logic [3:0] sat_up(input logic [3:0] a);
		return (a < tcd_pkg::ACTIVE_MAX) ? a + 4'd1 : a;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void dispatch_event(input dispatch_req_t ev);
		tcd_pkg::task_t job;
		tcd_pkg::task_t res;
		logic           have;
		logic           kind;
		logic           check_normal;
		int             limit;
		outcome_t       o;
		job = '{op: ev.op, box: ev.box, tag: ev.tag};
		res = job;
		have = 1'b0;
		kind = tcd_pkg::RES_DISPATCH;
		check_normal = 1'b0;
		limit = (int'(pred_max_waiting) < tcd_pkg::QUEUE_DEPTH) ? int'(pred_max_waiting)
			: tcd_pkg::QUEUE_DEPTH;
		if (ev.req == tcd_pkg::REQ_TASK && ev.op == tcd_pkg::OP_OPEN) begin
			if (pred_mode == tcd_pkg::MODE_URGENT) begin
				if (urgent_wait.size() < limit) begin
					urgent_wait.insert(urgent_wait.size(), job);
				end else begin
					have = 1'b1;
					kind = tcd_pkg::RES_BUSY;
				end
			end else begin
				have = 1'b1;
				pred_mode = tcd_pkg::MODE_URGENT;
				pred_active = sat_up(pred_active);
			end
		end else if (ev.req == tcd_pkg::REQ_TASK && ev.op <= tcd_pkg::OP_BATTERY) begin
			if (pred_mode != tcd_pkg::MODE_IDLE) begin
				if (normal_wait.size() < limit) begin
					normal_wait.insert(normal_wait.size(), job);
				end else begin
					have = 1'b1;
					kind = tcd_pkg::RES_BUSY;
				end
			end else begin
				have = 1'b1;
				pred_mode = tcd_pkg::MODE_NORMAL;
				pred_active = sat_up(pred_active);
			end
		end else if (ev.req == tcd_pkg::REQ_DONE_A || ev.req == tcd_pkg::REQ_DONE_B) begin
			if (pred_active != 4'd0)
				pred_active = pred_active - 4'd1;
			if (ev.req == tcd_pkg::REQ_DONE_A) begin
				if (urgent_wait.size() != 0) begin
					have = 1'b1;
					res = urgent_wait[0];
					urgent_wait.delete(0);
					pred_mode = tcd_pkg::MODE_URGENT;
					pred_active = sat_up(pred_active);
				end else begin
					pred_mode = tcd_pkg::MODE_NORMAL;
					check_normal = (pred_active == 4'd0);
				end
			end else begin
				check_normal = (pred_mode != tcd_pkg::MODE_URGENT && pred_active == 4'd0);
			end
			if (check_normal) begin
				if (normal_wait.size() != 0) begin
					have = 1'b1;
					res = normal_wait[0];
					normal_wait.delete(0);
					pred_mode = tcd_pkg::MODE_NORMAL;
					pred_active = sat_up(pred_active);
				end else begin
					pred_mode = tcd_pkg::MODE_IDLE;
				end
			end
		end
		if (pred_mode == tcd_pkg::MODE_IDLE && !have) begin
			if (urgent_wait.size() != 0) begin
				have = 1'b1;
				res = urgent_wait[0];
				urgent_wait.delete(0);
				pred_mode = tcd_pkg::MODE_URGENT;
				pred_active = sat_up(pred_active);
			end else if (normal_wait.size() != 0) begin
				have = 1'b1;
				res = normal_wait[0];
				normal_wait.delete(0);
				pred_mode = tcd_pkg::MODE_NORMAL;
				pred_active = sat_up(pred_active);
			end
		end
		if (have) begin
			o = '{kind: kind, job: res, mode: pred_mode, active: pred_active,
				urgent_fill: 6'(urgent_wait.size()), normal_fill: 6'(normal_wait.size())};
			expected_results.insert(expected_results.size(), o);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			task_ch.valid    <= 1'b0;
			task_ch.req_type <= tcd_pkg::REQ_TASK;
			task_ch.task_op  <= tcd_pkg::OP_OPEN;
			task_ch.box_id   <= '0;
			task_ch.task_tag <= '0;
			send_gap = 0;
		end else begin
			if (task_ch.valid && task_ch.ready) begin
				dispatch_event(on_wire);
				send_gap = pick_gap();
			end
			if (!task_ch.valid || task_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					task_ch.valid <= 1'b0;
				end else if (pending_events.size() != 0) begin
					on_wire = pending_events[0];
					pending_events.delete(0);
					task_ch.valid    <= 1'b1;
					task_ch.req_type <= on_wire.req;
					task_ch.task_op  <= on_wire.op;
					task_ch.box_id   <= on_wire.box;
					task_ch.task_tag <= on_wire.tag;
				end else begin
					task_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		outcome_t got;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got = '{kind: result_ch.result_kind,
					job: '{op: result_ch.out_op, box: result_ch.out_box, tag: result_ch.out_tag},
					mode: result_ch.mode_now, active: result_ch.active_now,
					urgent_fill: result_ch.urgent_waiting, normal_fill: result_ch.normal_waiting};
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat, expected none, actual %p", $time, got);
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					if (got !== want) begin
						errors++;
						$display("%0t: result beat differs, expected %p, actual %p",
							$time, want, got);
					end
				end
			end
			if (rx_hold) begin
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				stall_left = ($urandom_range(0, 4) == 0) ? pick_gap() : 0;
			end
		end
	end

	initial begin
		wait (pressure_go);
		@(negedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		#(12 * 800000);
		$display("two_class_task_dispatcher_core: mismatch");
		$finish;
	end

	task automatic add_event(input logic [1:0] req, input logic [2:0] op,
		input logic [7:0] box, input logic [15:0] tag);
		dispatch_req_t ev;
		ev = '{req: req, op: op, box: box, tag: tag};
		pending_events.insert(pending_events.size(), ev);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_events.size() != 0 || task_ch.valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_max_waiting(input logic [5:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(tcd_pkg::REG_MAX_WAITING * 4);
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		pred_max_waiting = value;
	endtask

	task automatic run_random(input logic [5:0] limit, input int count, input int task_pct);
		int          r;
		logic [1:0]  req;
		logic [2:0]  op;
		logic [7:0]  box;
		logic [15:0] tag;
		write_max_waiting(limit);
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < task_pct)
				req = tcd_pkg::REQ_TASK;
			else if (r < task_pct + (97 - task_pct) / 2)
				req = tcd_pkg::REQ_DONE_A;
			else if (r < 97)
				req = tcd_pkg::REQ_DONE_B;
			else
				req = REQ_OTHER;
			if ($urandom_range(0, 19) == 0)
				op = 3'($urandom_range(5, 7));
			else if ($urandom_range(0, 9) < 4)
				op = tcd_pkg::OP_OPEN;
			else
				op = 3'($urandom_range(1, 4));
			if ($urandom_range(0, 3) == 0)
				box = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			else
				box = 8'($urandom);
			if ($urandom_range(0, 3) == 0)
				tag = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			else
				tag = 16'($urandom);
			add_event(req, op, box, tag);
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pred_mode = tcd_pkg::MODE_IDLE;
		pred_active = 4'd0;
		pred_max_waiting = tcd_pkg::MAX_WAITING_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Completions and other events while idle, then both classes
		// queueing behind the executor and draining again.
		add_event(tcd_pkg::REQ_DONE_A, tcd_pkg::OP_OPEN, 8'h00, 16'h0000);
		add_event(tcd_pkg::REQ_DONE_B, tcd_pkg::OP_OPEN, 8'h00, 16'h0000);
		add_event(REQ_OTHER, OP_CLOSE, 8'h5A, 16'h1234);
		add_event(tcd_pkg::REQ_TASK, 3'd7, 8'hFF, 16'hFFFF);
		add_event(tcd_pkg::REQ_TASK, OP_CLOSE, 8'h00, 16'h0000);
		add_event(tcd_pkg::REQ_TASK, tcd_pkg::OP_OPEN, 8'hFF, 16'hFFFF);
		add_event(tcd_pkg::REQ_TASK, tcd_pkg::OP_OPEN, 8'h12, 16'h8001);
		add_event(tcd_pkg::REQ_TASK, tcd_pkg::OP_BATTERY, 8'hFF, 16'h0000);
		add_event(tcd_pkg::REQ_TASK, OP_PAPER_STAT, 8'h00, 16'hFFFF);
		add_event(tcd_pkg::REQ_TASK, OP_DOOR_STAT, 8'hA5, 16'h5AA5);
		add_event(tcd_pkg::REQ_DONE_B, tcd_pkg::OP_OPEN, 8'h00, 16'h0000);
		add_event(tcd_pkg::REQ_DONE_A, tcd_pkg::OP_OPEN, 8'h00, 16'h0000);
		add_event(tcd_pkg::REQ_DONE_A, tcd_pkg::OP_OPEN, 8'h00, 16'h0000);
		add_event(tcd_pkg::REQ_DONE_B, tcd_pkg::OP_OPEN, 8'h00, 16'h0000);
		add_event(tcd_pkg::REQ_DONE_A, tcd_pkg::OP_OPEN, 8'h00, 16'h0000);
		add_event(tcd_pkg::REQ_DONE_A, tcd_pkg::OP_OPEN, 8'h00, 16'h0000);
		drain();

		write_max_waiting(6'd1);
		add_event(tcd_pkg::REQ_TASK, OP_CLOSE, 8'h01, 16'h0001);
		add_event(tcd_pkg::REQ_TASK, OP_CLOSE, 8'h02, 16'h0002);
		add_event(tcd_pkg::REQ_TASK, tcd_pkg::OP_BATTERY, 8'h03, 16'h0003);
		add_event(tcd_pkg::REQ_TASK, tcd_pkg::OP_OPEN, 8'h04, 16'h0004);
		add_event(tcd_pkg::REQ_TASK, tcd_pkg::OP_OPEN, 8'h05, 16'h0005);
		add_event(tcd_pkg::REQ_TASK, tcd_pkg::OP_OPEN, 8'h06, 16'h0006);
		add_event(tcd_pkg::REQ_DONE_A, tcd_pkg::OP_OPEN, 8'h00, 16'h0000);
		add_event(tcd_pkg::REQ_DONE_A, tcd_pkg::OP_OPEN, 8'h00, 16'h0000);
		add_event(tcd_pkg::REQ_DONE_B, tcd_pkg::OP_OPEN, 8'h00, 16'h0000);
		drain();

		write_max_waiting(6'd0);
		add_event(tcd_pkg::REQ_TASK, OP_CLOSE, 8'h07, 16'h0007);
		add_event(tcd_pkg::REQ_TASK, OP_DOOR_STAT, 8'h08, 16'h0008);
		add_event(tcd_pkg::REQ_TASK, tcd_pkg::OP_OPEN, 8'h09, 16'h0009);
		add_event(tcd_pkg::REQ_TASK, tcd_pkg::OP_OPEN, 8'h0A, 16'h000A);
		add_event(tcd_pkg::REQ_DONE_A, tcd_pkg::OP_OPEN, 8'h00, 16'h0000);
		drain();

		pressure_go = 1'b1;
		run_random(6'd32, 300, 90);
		run_random(6'd63, 250, 60);
		quiet = 1'b1;
		run_random(6'd1, 250, 55);
		quiet = 1'b0;
		run_random(6'd5, 250, 70);
		run_random(6'd0, 150, 60);
		run_random(6'd17, 300, 80);
		run_random(tcd_pkg::MAX_WAITING_RESET, 300, 65);

		repeat (20) @(negedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("two_class_task_dispatcher_core: match");
		end else begin
			$display("two_class_task_dispatcher_core: mismatch");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/tcd_pkg.sv
design/tcd_task_if.sv
design/tcd_result_if.sv
design/tcd_ram.sv
design/two_class_task_dispatcher_core.sv
design/tcd_checker.sv
sim/tb_two_class_task_dispatcher_core.sv
